/* hdl/lcdseq_pkg.sv */
// Package: request codes, word types and timing constants of the LCD command sequencer.
package lcdseq_pkg;

    localparam int unsigned GLYPH_ROWS = 8;

    localparam logic [3:0] REQ_INIT      = 4'd0;
    localparam logic [3:0] REQ_COMMAND   = 4'd1;
    localparam logic [3:0] REQ_DATA      = 4'd2;
    localparam logic [3:0] REQ_CLEAR     = 4'd3;
    localparam logic [3:0] REQ_HOME      = 4'd4;
    localparam logic [3:0] REQ_CURSOR    = 4'd5;
    localparam logic [3:0] REQ_DISPLAY   = 4'd6;
    localparam logic [3:0] REQ_SHOW      = 4'd7;
    localparam logic [3:0] REQ_BLINK     = 4'd8;
    localparam logic [3:0] REQ_SCROLL    = 4'd9;
    localparam logic [3:0] REQ_DIRECTION = 4'd10;
    localparam logic [3:0] REQ_AUTOSCROLL = 4'd11;
    localparam logic [3:0] REQ_GLYPH     = 4'd12;

    localparam logic [1:0] REG_FOUR_BIT  = 2'd0;
    localparam logic [1:0] REG_NUM_LINES = 2'd1;
    localparam logic [1:0] REG_TALL_FONT = 2'd2;

    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_ENTRY     = 8'h04;
    localparam logic [7:0] CMD_CONTROL   = 8'h08;
    localparam logic [7:0] CMD_SHIFT     = 8'h18;
    localparam logic [7:0] CMD_FUNCTION  = 8'h20;
    localparam logic [7:0] CMD_CGRAM     = 8'h40;
    localparam logic [7:0] CMD_DDRAM     = 8'h80;
    localparam logic [3:0] NIB_WAKE      = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT  = 4'h2;

    localparam logic [6:0] ROW1_BASE = 7'h40;
    localparam logic [6:0] ROW2_BASE = 7'h14;
    localparam logic [6:0] ROW3_BASE = 7'h54;

    localparam logic [2:0] DC_INIT = 3'b100;
    localparam logic [1:0] EM_INIT = 2'b10;

    localparam logic [15:0] WAIT_SETTLE  = 16'd100;
    localparam logic [15:0] WAIT_POWERUP = 16'd50000;
    localparam logic [15:0] EXTRA_LONG   = 16'd4500;
    localparam logic [15:0] EXTRA_SHORT  = 16'd150;
    localparam logic [15:0] EXTRA_CLEAR  = 16'd2000;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_GLYPH,
        KIND_INIT
    } kind_t;

    typedef enum logic [1:0] {
        EX_NONE,
        EX_SHORT,
        EX_CLEAR,
        EX_LONG
    } extra_t;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [7:0]  value;
        logic [5:0]  column;
        logic [1:0]  row;
        logic        flag;
        logic [2:0]  slot;
        logic [63:0] glyph;
    } req_word_t;

    typedef struct packed {
        logic        reg_select;
        logic [7:0]  data_bits;
        logic        enable_pulse;
        logic [15:0] wait_after_us;
        logic        last;
    } xfer_word_t;

    typedef struct packed {
        logic       four_bit_mode;
        logic [2:0] num_lines;
        logic       tall_font;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic       rs;
        logic [7:0] code;
        extra_t     extra;
    } item_t;

    function automatic logic [15:0] extra_us(extra_t ex);
        logic [15:0] us;
        unique case (ex)
            EX_SHORT: us = EXTRA_SHORT;
            EX_CLEAR: us = EXTRA_CLEAR;
            EX_LONG:  us = EXTRA_LONG;
            default:  us = 16'd0;
        endcase
        return us;
    endfunction

endpackage

/* hdl/lcdseq_decode.sv */
// Request decoder: turns one request into a sequence descriptor and updates mode bits.
module lcdseq_decode (
    input  lcdseq_pkg::req_word_t req,
    input  lcdseq_pkg::cfg_t      cfg,
    input  logic [2:0]            dc_bits,
    input  logic [1:0]            em_bits,
    output lcdseq_pkg::item_t     item,
    output logic                  emits,
    output logic [2:0]            dc_next,
    output logic [1:0]            em_next
);

    logic [7:0] fs;
    logic [1:0] row_eff;
    logic [6:0] row_base;
    logic [6:0] ddram_addr;
    logic [2:0] dc_bit;
    logic [1:0] em_bit;

    always_comb
    begin
        fs = lcdseq_pkg::CMD_FUNCTION;
        if (!cfg.four_bit_mode)
        begin
            fs[4] = 1'b1;
        end
        if (cfg.num_lines > 3'd1)
        begin
            fs[3] = 1'b1;
        end
        if (cfg.tall_font && (cfg.num_lines == 3'd1))
        begin
            fs[2] = 1'b1;
        end
    end

    always_comb
    begin
        row_eff = req.row;
        if ({1'b0, req.row} >= cfg.num_lines)
        begin
            row_eff = (cfg.num_lines == 3'd0) ? 2'd0 : cfg.num_lines[1:0] - 2'd1;
        end
        case (row_eff)
            2'd1:    row_base = lcdseq_pkg::ROW1_BASE;
            2'd2:    row_base = lcdseq_pkg::ROW2_BASE;
            2'd3:    row_base = lcdseq_pkg::ROW3_BASE;
            default: row_base = 7'd0;
        endcase
        ddram_addr = {1'b0, req.column} + row_base;
    end

    always_comb
    begin
        case (req.req_type)
            lcdseq_pkg::REQ_DISPLAY: dc_bit = 3'b100;
            lcdseq_pkg::REQ_SHOW:    dc_bit = 3'b010;
            default:                 dc_bit = 3'b001;
        endcase
        em_bit = (req.req_type == lcdseq_pkg::REQ_DIRECTION) ? 2'b10 : 2'b01;
    end

    always_comb
    begin
        item.kind  = lcdseq_pkg::KIND_BYTE;
        item.rs    = 1'b0;
        item.code  = req.value;
        item.extra = lcdseq_pkg::EX_NONE;
        emits      = 1'b1;
        dc_next    = dc_bits;
        em_next    = em_bits;
        unique case (req.req_type) inside
            lcdseq_pkg::REQ_INIT:
            begin
                item.kind = lcdseq_pkg::KIND_INIT;
                item.code = fs;
                dc_next   = lcdseq_pkg::DC_INIT;
                em_next   = lcdseq_pkg::EM_INIT;
            end
            lcdseq_pkg::REQ_COMMAND:
            begin
                item.code = req.value;
            end
            lcdseq_pkg::REQ_DATA:
            begin
                item.rs = 1'b1;
            end
            lcdseq_pkg::REQ_CLEAR:
            begin
                item.code  = lcdseq_pkg::CMD_CLEAR;
                item.extra = lcdseq_pkg::EX_CLEAR;
            end
            lcdseq_pkg::REQ_HOME:
            begin
                item.code  = lcdseq_pkg::CMD_HOME;
                item.extra = lcdseq_pkg::EX_CLEAR;
            end
            lcdseq_pkg::REQ_CURSOR:
            begin
                item.code = lcdseq_pkg::CMD_DDRAM | {1'b0, ddram_addr};
            end
            lcdseq_pkg::REQ_DISPLAY, lcdseq_pkg::REQ_SHOW, lcdseq_pkg::REQ_BLINK:
            begin
                dc_next   = req.flag ? (dc_bits | dc_bit) : (dc_bits & ~dc_bit);
                item.code = lcdseq_pkg::CMD_CONTROL | {5'd0, dc_next};
            end
            lcdseq_pkg::REQ_SCROLL:
            begin
                item.code = lcdseq_pkg::CMD_SHIFT | {5'd0, req.flag, 2'd0};
            end
            lcdseq_pkg::REQ_DIRECTION, lcdseq_pkg::REQ_AUTOSCROLL:
            begin
                em_next   = req.flag ? (em_bits | em_bit) : (em_bits & ~em_bit);
                item.code = lcdseq_pkg::CMD_ENTRY | {6'd0, em_next};
            end
            lcdseq_pkg::REQ_GLYPH:
            begin
                item.kind = lcdseq_pkg::KIND_GLYPH;
                item.code = lcdseq_pkg::CMD_CGRAM | {2'd0, req.slot, 3'd0};
            end
            default:
            begin
                emits = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/lcdseq_step.sv */
// Step generator: forms the bus word for one step of the current request.
module lcdseq_step (
    input  lcdseq_pkg::item_t      item,
    input  logic [63:0]            glyph,
    input  lcdseq_pkg::cfg_t       cfg,
    input  logic [4:0]             step,
    output lcdseq_pkg::xfer_word_t word
);

    logic        nib;
    logic [4:0]  prefix;
    logic [4:0]  rel;
    logic [3:0]  byte_idx;
    logic [2:0]  glyph_row;
    logic [2:0]  init_idx;
    logic [4:0]  total;
    logic        in_prefix;
    logic        rs;
    logic [7:0]  byte_val;
    lcdseq_pkg::extra_t extra;

    always_comb
    begin
        nib       = cfg.four_bit_mode;
        prefix    = (item.kind == lcdseq_pkg::KIND_INIT) ? (nib ? 5'd5 : 5'd1) : 5'd0;
        in_prefix = step < prefix;
        rel       = step - prefix;
        byte_idx  = nib ? rel[4:1] : rel[3:0];
        glyph_row = byte_idx[2:0] - 3'd1;
        init_idx  = byte_idx[2:0] + (nib ? 3'd3 : 3'd0);

        unique case (item.kind)
            lcdseq_pkg::KIND_GLYPH: total = nib ? 5'd18 : 5'd9;
            lcdseq_pkg::KIND_INIT:  total = nib ? 5'd13 : 5'd8;
            default:                total = nib ? 5'd2 : 5'd1;
        endcase

        rs       = item.rs;
        byte_val = item.code;
        extra    = item.extra;
        unique case (item.kind)
            lcdseq_pkg::KIND_GLYPH:
            begin
                if (byte_idx != 4'd0)
                begin
                    rs       = 1'b1;
                    byte_val = glyph[{glyph_row, 3'd0} +: 8];
                end
            end
            lcdseq_pkg::KIND_INIT:
            begin
                case (init_idx)
                    3'd0:    extra = lcdseq_pkg::EX_LONG;
                    3'd1:    extra = lcdseq_pkg::EX_SHORT;
                    3'd5:    extra = lcdseq_pkg::EX_CLEAR;
                    default: extra = lcdseq_pkg::EX_NONE;
                endcase
                case (init_idx)
                    3'd4:    byte_val = lcdseq_pkg::CMD_CONTROL | {5'd0, lcdseq_pkg::DC_INIT};
                    3'd5:    byte_val = lcdseq_pkg::CMD_CLEAR;
                    3'd6:    byte_val = lcdseq_pkg::CMD_ENTRY | {6'd0, lcdseq_pkg::EM_INIT};
                    default: byte_val = item.code;
                endcase
            end
            default:
            begin
            end
        endcase

        word.reg_select   = rs;
        word.enable_pulse = 1'b1;
        word.last         = (step == total - 5'd1);
        if (!nib)
        begin
            word.data_bits     = byte_val;
            word.wait_after_us = lcdseq_pkg::WAIT_SETTLE + lcdseq_pkg::extra_us(extra);
        end
        else if (rel[0])
        begin
            word.data_bits     = {4'd0, byte_val[3:0]};
            word.wait_after_us = lcdseq_pkg::WAIT_SETTLE + lcdseq_pkg::extra_us(extra);
        end
        else
        begin
            word.data_bits     = {4'd0, byte_val[7:4]};
            word.wait_after_us = lcdseq_pkg::WAIT_SETTLE;
        end

        if (in_prefix)
        begin
            word.reg_select = 1'b0;
            case (step)
                5'd0:
                begin
                    word.enable_pulse  = 1'b0;
                    word.data_bits     = 8'd0;
                    word.wait_after_us = lcdseq_pkg::WAIT_POWERUP;
                end
                5'd1, 5'd2:
                begin
                    word.data_bits     = {4'd0, lcdseq_pkg::NIB_WAKE};
                    word.wait_after_us = lcdseq_pkg::WAIT_SETTLE + lcdseq_pkg::EXTRA_LONG;
                end
                5'd3:
                begin
                    word.data_bits     = {4'd0, lcdseq_pkg::NIB_WAKE};
                    word.wait_after_us = lcdseq_pkg::WAIT_SETTLE + lcdseq_pkg::EXTRA_SHORT;
                end
                default:
                begin
                    word.data_bits     = {4'd0, lcdseq_pkg::NIB_FOUR_BIT};
                    word.wait_after_us = lcdseq_pkg::WAIT_SETTLE;
                end
            endcase
        end
    end

endmodule

/* hdl/char_lcd_command_sequencer_top.sv */
// Top level: LCD command sequencer with request channel, transfer channel and APB registers.
//
// Requests enter on req/req_valid/req_stall; a word is taken at a clock edge with
// req_valid high and req_stall low. Each request expands into 1 to 18 bus
// transfers (4-bit mode: 2 per byte; init 13, glyph load 18), leaving on
// xfer/xfer_valid/xfer_stall with last set on the final transfer.
// Transfers leave at one per cycle while the receiver does not stall; the step
// counter walks the request register through the request's transfers.
// A taken request goes into the request register, and its first transfer then
// into the output register. The next request is taken in the same cycle the
// final transfer of the current one moves into the output register, so requests
// run back to back; unused request codes are taken and dropped with no transfers.
// When the receiver stalls, the output register holds its word and the step
// counter stops. Reset clears both channels, sets four_bit_mode 1,
// num_lines 2, tall_font 0, and zeroes the display and entry-mode bits.
// Registers: 0x0 four_bit_mode, 0x4 num_lines, 0x8 tall_font; write them idle.
module char_lcd_command_sequencer_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  lcdseq_pkg::req_word_t  req,
    output logic                   xfer_valid,
    input  logic                   xfer_stall,
    output lcdseq_pkg::xfer_word_t xfer,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    lcdseq_pkg::cfg_t       cfg_reg;
    lcdseq_pkg::item_t      item_reg;
    lcdseq_pkg::item_t      item_dec;
    lcdseq_pkg::xfer_word_t step_word;
    lcdseq_pkg::xfer_word_t xfer_reg;
    logic                   item_valid_reg;
    logic [63:0]            glyph_reg;
    logic [4:0]             step_reg;
    logic [4:0]             step_next;
    logic [2:0]             dc_reg;
    logic [2:0]             dc_next;
    logic [1:0]             em_reg;
    logic [1:0]             em_next;
    logic                   xfer_valid_reg;
    logic                   emits;
    logic                   out_free;
    logic                   emit_step;
    logic                   item_done;
    logic                   req_take;
    logic                   cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            lcdseq_pkg::REG_FOUR_BIT:  prdata = {31'd0, cfg_reg.four_bit_mode};
            lcdseq_pkg::REG_NUM_LINES: prdata = {29'd0, cfg_reg.num_lines};
            lcdseq_pkg::REG_TALL_FONT: prdata = {31'd0, cfg_reg.tall_font};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.four_bit_mode <= 1'b1;
            cfg_reg.num_lines     <= 3'd2;
            cfg_reg.tall_font     <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                lcdseq_pkg::REG_FOUR_BIT:  cfg_reg.four_bit_mode <= pwdata[0];
                lcdseq_pkg::REG_NUM_LINES: cfg_reg.num_lines     <= pwdata[2:0];
                lcdseq_pkg::REG_TALL_FONT: cfg_reg.tall_font     <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    lcdseq_decode u_decode (
        .req     (req),
        .cfg     (cfg_reg),
        .dc_bits (dc_reg),
        .em_bits (em_reg),
        .item    (item_dec),
        .emits   (emits),
        .dc_next (dc_next),
        .em_next (em_next)
    );

    lcdseq_step u_step (
        .item  (item_reg),
        .glyph (glyph_reg),
        .cfg   (cfg_reg),
        .step  (step_reg),
        .word  (step_word)
    );

    assign out_free  = !xfer_valid_reg || !xfer_stall;
    assign emit_step = item_valid_reg && out_free;
    assign item_done = emit_step && step_word.last;
    assign req_stall = item_valid_reg && !item_done;
    assign req_take  = req_valid && !req_stall;
    assign step_next = item_done ? 5'd0 : step_reg + 5'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            step_reg       <= 5'd0;
            dc_reg         <= 3'd0;
            em_reg         <= 2'd0;
            xfer_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit_step)
            begin
                step_reg <= step_next;
            end
            if (req_take)
            begin
                item_valid_reg <= emits;
                dc_reg         <= dc_next;
                em_reg         <= em_next;
            end
            else if (item_done)
            begin
                item_valid_reg <= 1'b0;
            end
            if (emit_step)
            begin
                xfer_valid_reg <= 1'b1;
            end
            else if (!xfer_stall)
            begin
                xfer_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            item_reg  <= item_dec;
            glyph_reg <= req.glyph;
        end
        if (emit_step)
        begin
            xfer_reg <= step_word;
        end
    end

    assign xfer_valid = xfer_valid_reg;
    assign xfer       = xfer_reg;

endmodule

/* hdl/lcdseq_checker.sv */
// Port checker for the LCD command sequencer, bound to the top level.
module lcdseq_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   xfer_valid,
    input logic                   xfer_stall,
    input lcdseq_pkg::xfer_word_t xfer
);

    assert property (@(posedge clk) disable iff (!rst_n)
        xfer_valid && xfer_stall |=> xfer_valid && $stable(xfer))
    else $error("stalled transfer word changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        xfer_valid && !xfer.enable_pulse |->
            !xfer.reg_select && (xfer.data_bits == 8'd0) &&
            (xfer.wait_after_us == lcdseq_pkg::WAIT_POWERUP) && !xfer.last)
    else $error("malformed power-up wait");

    assert property (@(posedge clk) disable iff (!rst_n)
        xfer_valid && xfer.reg_select |->
            xfer.enable_pulse && (xfer.wait_after_us == lcdseq_pkg::WAIT_SETTLE))
    else $error("data transfer with wrong settle time");

    assert property (@(posedge clk) disable iff (!rst_n)
        xfer_valid && xfer.enable_pulse |->
            (xfer.wait_after_us >= lcdseq_pkg::WAIT_SETTLE) &&
            (xfer.wait_after_us <= lcdseq_pkg::WAIT_SETTLE + lcdseq_pkg::EXTRA_LONG))
    else $error("pulsed transfer wait out of range");

endmodule

bind char_lcd_command_sequencer_top lcdseq_checker u_lcdseq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .xfer_valid (xfer_valid),
    .xfer_stall (xfer_stall),
    .xfer       (xfer)
);
